// ----- src/positional_list_engine_top_assert.svh -----
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition holds in the same cycle as the trigger.
`define PLE_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");
// Condition holds in the cycle after the trigger.
`define PLE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");
`else
`define PLE_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define PLE_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif
`endif

// ----- src/ple_pkg.sv -----
// Types and constants of the positional list engine.
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_LOCATE = 2'd3
    } t_cmd;

endpackage

// ----- src/ple_ram.sv -----
// List storage: one write port, one read port with registered read data.
module ple_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ple_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [ple_pkg::DATA_W-1:0] o_rdata
);

    logic [ple_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/positional_list_engine_top.sv -----
// Top level of the positional list engine: request sequencer over the list memory.
//
// A packed list of up to CAPACITY signed 32-bit entries, addressed by 1-based
// position. A request (i_cmd, i_position, i_value) is taken on a clock edge
// with start high and busy low; unless rejected, busy stays high until it is
// done. Every request gives exactly one result beat, shown for one cycle with
// o_valid high; the receiver cannot stall it, so it must sample on that edge.
// The list lives in a single-port-read, single-port-write memory and every
// step walks it one entry per cycle through that read port: the shift of an
// insert or delete moves one entry a cycle, and locate compares one entry a
// cycle. An insert shifts the entries from its position up and then writes
// the value; an append at position length + 1 skips the shift. A delete
// shifts the later entries down, a get reads one entry, and a locate stops
// on an early match. Any rejected request (bad position, full or empty list)
// is answered at once, with the list untouched.
// o_count is the length after the request, o_found_at is zero except for a
// locate hit, o_element is zero except for a good get or delete.
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    output logic                              o_status,
    output logic signed [ple_pkg::DATA_W-1:0] o_element,
    output logic [ple_pkg::CNT_W-1:0]         o_found_at,
    output logic [ple_pkg::CNT_W-1:0]         o_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    // compare width wide enough for both a position and a length, plus one
    localparam int CW = ((LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W) + 1;
    localparam int DW = ple_pkg::DATA_W;
    localparam int NW = ple_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUT
    } t_state;

    t_state                 r_state, n_state;
    ple_pkg::t_cmd          r_cmd, n_cmd;
    logic [DW-1:0]          r_val, n_val;
    logic [AW-1:0]          r_pa, n_pa;        // position - 1
    logic [AW-1:0]          r_ptr, n_ptr;      // next read address
    logic [AW-1:0]          r_end, n_end;      // last read address
    logic                   r_more, n_more;    // reads still to issue
    logic                   r_pv, n_pv;        // read data due this cycle
    logic [AW-1:0]          r_paddr, n_paddr;  // address of that read
    logic [LW-1:0]          r_len, n_len;
    logic [DW-1:0]          r_elem, n_elem;
    logic [NW-1:0]          r_found, n_found;
    logic                   n_o_valid;
    logic                   n_o_status;
    logic [DW-1:0]          n_o_element;
    logic [NW-1:0]          n_o_found_at;
    logic [NW-1:0]          n_o_count;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [DW-1:0]          w_wdata;
    logic [AW-1:0]          w_raddr;
    logic [DW-1:0]          w_rdata;

    logic [CW-1:0]          w_pos;
    logic [CW-1:0]          w_lenx;
    logic [CW-1:0]          w_pm1;
    logic                   w_pos_bad_ins;
    logic                   w_pos_bad_rd;
    logic                   w_full;
    logic                   w_fail;
    logic                   w_hit;

    ple_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy = (r_state != S_IDLE);

    // Request checks on the raw input fields.
    assign w_pos         = CW'(i_position);
    assign w_lenx        = CW'(r_len);
    assign w_pm1         = w_pos - 1'b1;
    assign w_full        = (r_len == LW'(CAPACITY));
    assign w_pos_bad_ins = (w_pos == '0) || (w_pos > (w_lenx + 1'b1));
    assign w_pos_bad_rd  = (w_pos == '0) || (w_pos > w_lenx);

    always_comb begin
        unique case (ple_pkg::t_cmd'(i_cmd))
            ple_pkg::CMD_INSERT: w_fail = w_full || w_pos_bad_ins;
            ple_pkg::CMD_DELETE: w_fail = w_pos_bad_rd;
            ple_pkg::CMD_GET:    w_fail = w_pos_bad_rd;
            ple_pkg::CMD_LOCATE: w_fail = 1'b0;
            default:             w_fail = 1'b1;
        endcase
    end

    // Locate hit on the entry read last cycle.
    assign w_hit = r_pv && (r_cmd == ple_pkg::CMD_LOCATE) && (w_rdata == r_val);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_pa         = r_pa;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_more       = r_more;
        n_pv         = 1'b0;
        n_paddr      = r_paddr;
        n_len        = r_len;
        n_elem       = r_elem;
        n_found      = r_found;
        n_o_valid    = 1'b0;
        n_o_status   = o_status;
        n_o_element  = o_element;
        n_o_found_at = o_found_at;
        n_o_count    = o_count;
        w_we         = 1'b0;
        w_waddr      = r_paddr;
        w_wdata      = w_rdata;
        w_raddr      = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = ple_pkg::t_cmd'(i_cmd);
                    n_val   = i_value;
                    n_pa    = AW'(w_pm1);
                    n_elem  = '0;
                    n_found = '0;
                    if (w_fail) begin
                        // Reject: answer at once, list untouched.
                        n_o_valid    = 1'b1;
                        n_o_status   = 1'b1;
                        n_o_element  = '0;
                        n_o_found_at = '0;
                        n_o_count    = NW'(r_len);
                    end else begin
                        n_state = S_WALK;
                        unique case (ple_pkg::t_cmd'(i_cmd))
                            ple_pkg::CMD_INSERT: begin
                                // walk down from the last entry to position - 1
                                n_ptr  = AW'(w_lenx - 1'b1);
                                n_end  = AW'(w_pm1);
                                n_more = (w_pos <= w_lenx);
                            end
                            ple_pkg::CMD_DELETE: begin
                                n_ptr  = AW'(w_pm1);
                                n_end  = AW'(w_lenx - 1'b1);
                                n_more = 1'b1;
                            end
                            ple_pkg::CMD_GET: begin
                                n_ptr  = AW'(w_pm1);
                                n_end  = AW'(w_pm1);
                                n_more = 1'b1;
                            end
                            default: begin
                                n_ptr  = '0;
                                n_end  = AW'(w_lenx - 1'b1);
                                n_more = (r_len != '0);
                            end
                        endcase
                    end
                end
            end

            S_WALK: begin
                // Consume the entry read last cycle.
                if (r_pv) begin
                    unique case (r_cmd)
                        ple_pkg::CMD_INSERT: begin
                            w_we    = 1'b1;
                            w_waddr = r_paddr + 1'b1;
                        end
                        ple_pkg::CMD_DELETE: begin
                            if (r_paddr == r_pa) begin
                                n_elem = w_rdata;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_paddr - 1'b1;
                            end
                        end
                        ple_pkg::CMD_GET: begin
                            n_elem = w_rdata;
                        end
                        default: begin
                            if (w_hit) begin
                                n_found = NW'({1'b0, r_paddr} + 1'b1);
                                n_more  = 1'b0;
                            end
                        end
                    endcase
                end
                // Issue the next read unless a match ended the search.
                if (r_more && !w_hit) begin
                    n_pv    = 1'b1;
                    n_paddr = r_ptr;
                    if (r_ptr == r_end) begin
                        n_more = 1'b0;
                    end else if (r_cmd == ple_pkg::CMD_INSERT) begin
                        n_ptr = r_ptr - 1'b1;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                // Pipeline drained: finish.
                if (!r_pv && !r_more) begin
                    if (r_cmd == ple_pkg::CMD_INSERT) begin
                        n_state = S_PUT;
                    end else begin
                        if (r_cmd == ple_pkg::CMD_DELETE) begin
                            n_len = r_len - 1'b1;
                        end
                        n_state      = S_IDLE;
                        n_o_valid    = 1'b1;
                        n_o_status   = 1'b0;
                        n_o_element  = r_elem;
                        n_o_found_at = r_found;
                        n_o_count    = NW'(n_len);
                    end
                end
            end

            S_PUT: begin
                w_we         = 1'b1;
                w_waddr      = r_pa;
                w_wdata      = r_val;
                n_len        = r_len + 1'b1;
                n_state      = S_IDLE;
                n_o_valid    = 1'b1;
                n_o_status   = 1'b0;
                n_o_element  = '0;
                n_o_found_at = '0;
                n_o_count    = NW'(n_len);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_pa       <= n_pa;
        r_ptr      <= n_ptr;
        r_end      <= n_end;
        r_paddr    <= n_paddr;
        r_elem     <= n_elem;
        r_found    <= n_found;
        o_status   <= n_o_status;
        o_element  <= n_o_element;
        o_found_at <= n_o_found_at;
        o_count    <= n_o_count;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
            r_pv    <= 1'b0;
            r_len   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
            r_pv    <= n_pv;
            r_len   <= n_len;
            o_valid <= n_o_valid;
        end
    end

    // An accepted request either starts a walk or answers on the next edge.
    `PLE_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, start && !busy, busy || o_valid)
    // The length never runs past the capacity.
    `PLE_ASSERT_SAME(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(CAPACITY))
    // A failed beat carries no element and no match.
    `PLE_ASSERT_SAME(a_fail_clean, i_clk, i_rst_n, o_valid && o_status, o_element == '0 && o_found_at == '0)
    // Read data is only pending while walking.
    `PLE_ASSERT_SAME(a_pv_walk, i_clk, i_rst_n, r_pv, r_state == S_WALK)

endmodule
